// ===== hdl/mcpd_pkg.sv =====
`timescale 1ns / 1ps

package mcpd_pkg;

    // Sizes of the dispatcher.
    localparam int NUM_CPUS     = 8;
    localparam int CPU_W        = 3;
    localparam int QUEUE_DEPTH  = 64;
    localparam int QIDX_W       = 6;
    localparam int QCNT_W       = 7;
    localparam int TOP_PRIORITY = 9;
    localparam int NUM_PRIOS    = TOP_PRIORITY + 1;
    localparam int PRIO_W       = 4;
    localparam int ID_W         = 16;
    localparam int CNT_W        = 32;
    localparam int CFG_W        = 4;
    localparam int KIND_W       = 2;
    localparam int STAT_W       = 4;
    localparam int SLICE_BASE   = 20;
    localparam int DUR_W        = 5;

    // Input word kinds.
    localparam logic [KIND_W-1:0] KIND_NEW    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STATS  = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } task_t;

    // Control of the ready store from the sequencer.
    typedef struct packed {
        logic              rd_en;
        logic [QIDX_W-1:0] rd_addr;
        logic              wr_en;
        logic [QIDX_W-1:0] wr_addr;
        task_t             wr_data;
        logic              clr_en;
        logic [QIDX_W-1:0] clr_addr;
    } store_ctrl_t;

    // Ordering of tasks by priority first, then by id.
    function automatic logic task_less(input task_t a, input task_t b);
        logic res;
        if (a.prio != b.prio)
        begin
            res = (a.prio < b.prio);
        end
        else
        begin
            res = (a.id < b.id);
        end
        return res;
    endfunction

endpackage

// ===== hdl/multi_cpu_priority_dispatcher_top.sv =====
`timescale 1ns / 1ps
// A status word that ends a busy slice makes 3 or 4 counter updates through one saturating adder
// before the scan; new-task, stats and ignored status words go straight to the scan.
// The scan reads the 64-entry ready store, one entry a cycle.
// One word is in work at a time; the next is taken while the last result waits.
// Reset (rst_n, asynchronous) empties the store, idles all CPUs and zeroes all totals.
module multi_cpu_priority_dispatcher_top
    import mcpd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [KIND_W-1:0]   kind,
    input  logic [ID_W-1:0]     task_id,
    input  logic [PRIO_W-1:0]   task_priority,
    input  logic [CPU_W-1:0]    cpu_index,
    input  logic                finished,
    input  logic [STAT_W-1:0]   stat_index,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                dispatched,
    output logic [CPU_W-1:0]    dispatch_cpu,
    output logic [ID_W-1:0]     dispatch_task,
    output logic [PRIO_W-1:0]   dispatch_priority,
    output logic                dropped,
    output logic [CNT_W-1:0]    done_count,
    output logic [CNT_W-1:0]    busy_time,
    output logic [CNT_W-1:0]    round_count,
    output logic [CNT_W-1:0]    cpu_time,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TIME   = 3'd1;
    localparam logic [2:0] S_ROUND  = 3'd2;
    localparam logic [2:0] S_CPUT   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;
    localparam logic [2:0] S_SCAN   = 3'd5;
    localparam logic [2:0] S_DECIDE = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [CFG_W-1:0] cfg_reg;

    // Latched word.
    logic [KIND_W-1:0] kind_reg;
    logic [STAT_W-1:0] stat_reg;
    logic              fin_reg;
    logic [CPU_W-1:0]  ci_reg;
    logic [PRIO_W-1:0] tp_reg;
    task_t             extra_reg;
    logic              have_extra_reg;

    // CPU slots and totals.
    logic [NUM_CPUS-1:0] busy_reg;
    task_t               slot_task_reg   [NUM_CPUS];
    logic [CNT_W-1:0]    prio_done_reg   [NUM_PRIOS];
    logic [CNT_W-1:0]    prio_time_reg   [NUM_PRIOS];
    logic [CNT_W-1:0]    prio_rounds_reg [NUM_PRIOS];
    logic [CNT_W-1:0]    cpu_totals_reg  [NUM_CPUS];

    // Scan state.
    logic [QCNT_W-1:0] scan_cnt_reg;
    logic              pipe_vld_reg;
    logic [QIDX_W-1:0] pipe_idx_reg;
    logic              best_vld_reg;
    logic [QIDX_W-1:0] best_idx_reg;
    task_t             best_task_reg;
    logic              free_found_reg;
    logic [QIDX_W-1:0] free_idx_reg;

    // Result word.
    logic              out_valid_reg;
    logic              disp_reg;
    logic [CPU_W-1:0]  dcpu_reg;
    task_t             dtask_reg;
    logic              drop_reg;
    logic [CNT_W-1:0]  done_out_reg, time_out_reg, round_out_reg, cpu_out_reg;

    store_ctrl_t store_ctrl;
    task_t       rd_task;
    logic        rd_valid;

    logic in_acc, go;
    logic hit;
    task_t hit_task;
    logic [DUR_W-1:0] dur;
    logic [CNT_W-1:0] add_a, add_b, add_sum;
    logic [CNT_W:0]   add_full;
    logic [PRIO_W-1:0] pa;
    logic              prio_ok, cpu_ok;
    logic [CPU_W-1:0]  ca;
    logic [CNT_W-1:0]  pd_rd, pt_rd, pr_rd, ct_rd;
    logic [CFG_W-1:0]  lim;
    logic              fc_found;
    logic [CPU_W-1:0]  fc_idx;
    logic              extra_wins, pick_extra, pick_best, disp, keep, slot_ok;
    logic [QIDX_W-1:0] slot_idx;
    task_t             chosen;
    logic              scan_rd;

    mcpd_ready_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (store_ctrl),
        .rd_task  (rd_task),
        .rd_valid (rd_valid)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign go        = (state_reg == S_DECIDE) && (!out_valid_reg || !out_stall);

    // Slot of the CPU named by an arriving status word.
    assign hit      = (kind == KIND_STATUS) && busy_reg[cpu_index];
    assign hit_task = slot_task_reg[cpu_index];

    // Shared saturating adder, one counter per step.
    assign dur = DUR_W'(SLICE_BASE) - DUR_W'(tp_reg);
    always_comb
    begin
        case (state_reg)
            S_TIME:
            begin
                add_a = pt_rd;
                add_b = CNT_W'(dur);
            end
            S_ROUND:
            begin
                add_a = pr_rd;
                add_b = CNT_W'(1);
            end
            S_CPUT:
            begin
                add_a = ct_rd;
                add_b = CNT_W'(dur);
            end
            S_DONE:
            begin
                add_a = pd_rd;
                add_b = CNT_W'(1);
            end
            default:
            begin
                add_a = '0;
                add_b = '0;
            end
        endcase
    end
    assign add_full = {1'b0, add_a} + {1'b0, add_b};
    assign add_sum  = add_full[CNT_W] ? '1 : add_full[CNT_W-1:0];

    // One read address per totals array: the ended task's priority or CPU, or the stats index.
    assign pa      = (state_reg == S_DECIDE) ? stat_reg : tp_reg;
    assign prio_ok = (pa <= PRIO_W'(TOP_PRIORITY));
    assign ca      = (state_reg == S_DECIDE) ? stat_reg[CPU_W-1:0] : ci_reg;
    assign cpu_ok  = (state_reg != S_DECIDE) || (stat_reg < STAT_W'(NUM_CPUS));
    assign pd_rd   = prio_ok ? prio_done_reg[pa]   : '0;
    assign pt_rd   = prio_ok ? prio_time_reg[pa]   : '0;
    assign pr_rd   = prio_ok ? prio_rounds_reg[pa] : '0;
    assign ct_rd   = cpu_ok  ? cpu_totals_reg[ca]  : '0;

    // Usable CPU count and the lowest free CPU below it.
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            lim = CFG_W'(1);
        end
        else if (cfg_reg > CFG_W'(NUM_CPUS))
        begin
            lim = CFG_W'(NUM_CPUS);
        end
        else
        begin
            lim = cfg_reg;
        end
        fc_found = 1'b0;
        fc_idx   = '0;
        for (int i = 0; i < NUM_CPUS; i++)
        begin
            if (!fc_found && (CFG_W'(i) < lim) && !busy_reg[i])
            begin
                fc_found = 1'b1;
                fc_idx   = CPU_W'(i);
            end
        end
    end

    // Dispatch choice between the best stored task and the task carried by this word.
    assign extra_wins = have_extra_reg && (!best_vld_reg || task_less(extra_reg, best_task_reg));
    assign pick_extra = fc_found && extra_wins;
    assign pick_best  = fc_found && !extra_wins && best_vld_reg;
    assign disp       = pick_extra || pick_best;
    assign chosen     = pick_extra ? extra_reg : best_task_reg;
    assign keep       = have_extra_reg && !pick_extra;

    // Lowest empty slot once the dispatched entry is gone.
    always_comb
    begin
        if (pick_best && (!free_found_reg || (best_idx_reg < free_idx_reg)))
        begin
            slot_ok  = 1'b1;
            slot_idx = best_idx_reg;
        end
        else
        begin
            slot_ok  = free_found_reg;
            slot_idx = free_idx_reg;
        end
    end

    // Store port control.
    assign scan_rd = (state_reg == S_SCAN) && !scan_cnt_reg[QCNT_W-1];
    always_comb
    begin
        store_ctrl.rd_en    = scan_rd;
        store_ctrl.rd_addr  = scan_cnt_reg[QIDX_W-1:0];
        store_ctrl.wr_en    = go && keep && slot_ok;
        store_ctrl.wr_addr  = slot_idx;
        store_ctrl.wr_data  = extra_reg;
        store_ctrl.clr_en   = go && pick_best;
        store_ctrl.clr_addr = best_idx_reg;
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = hit ? S_TIME : S_SCAN;
                end
            end
            S_TIME:   state_next = S_ROUND;
            S_ROUND:  state_next = S_CPUT;
            S_CPUT:   state_next = fin_reg ? S_DONE : S_SCAN;
            S_DONE:   state_next = S_SCAN;
            S_SCAN:
            begin
                if (!scan_rd)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cfg_reg        <= CFG_W'(NUM_CPUS);
            have_extra_reg <= 1'b0;
            busy_reg       <= '0;
            out_valid_reg  <= 1'b0;
            scan_cnt_reg   <= '0;
            pipe_vld_reg   <= 1'b0;
            best_vld_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                slot_task_reg[i]  <= '0;
                cpu_totals_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_PRIOS; i++)
            begin
                prio_done_reg[i]   <= '0;
                prio_time_reg[i]   <= '0;
                prio_rounds_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end

            // Take a word: latch it, free the CPU whose slice ended, prepare the scan.
            if (in_acc)
            begin
                kind_reg       <= kind;
                stat_reg       <= stat_index;
                fin_reg        <= finished;
                ci_reg         <= cpu_index;
                tp_reg         <= hit_task.prio;
                scan_cnt_reg   <= '0;
                pipe_vld_reg   <= 1'b0;
                best_vld_reg   <= 1'b0;
                free_found_reg <= 1'b0;
                if (kind == KIND_NEW)
                begin
                    extra_reg.id   <= task_id;
                    extra_reg.prio <= (task_priority > PRIO_W'(TOP_PRIORITY)) ?
                                      PRIO_W'(TOP_PRIORITY) : task_priority;
                    have_extra_reg <= 1'b1;
                end
                else if (hit && !finished)
                begin
                    extra_reg.id   <= hit_task.id;
                    extra_reg.prio <= (hit_task.prio < PRIO_W'(TOP_PRIORITY)) ?
                                      hit_task.prio + PRIO_W'(1) : PRIO_W'(TOP_PRIORITY);
                    have_extra_reg <= 1'b1;
                end
                else
                begin
                    have_extra_reg <= 1'b0;
                end
                if (hit)
                begin
                    busy_reg[cpu_index]      <= 1'b0;
                    slot_task_reg[cpu_index] <= '0;
                end
            end

            // Counter updates of an ended slice.
            case (state_reg)
                S_TIME:   prio_time_reg[pa]   <= add_sum;
                S_ROUND:  prio_rounds_reg[pa] <= add_sum;
                S_CPUT:   cpu_totals_reg[ca]  <= add_sum;
                S_DONE:   prio_done_reg[pa]   <= add_sum;
                default:  ;
            endcase

            // Scan: issue one read a cycle, compare the entry read in the cycle before.
            if (state_reg == S_SCAN)
            begin
                pipe_vld_reg <= scan_rd;
                pipe_idx_reg <= scan_cnt_reg[QIDX_W-1:0];
                if (scan_rd)
                begin
                    scan_cnt_reg <= scan_cnt_reg + QCNT_W'(1);
                end
                if (pipe_vld_reg)
                begin
                    if (rd_valid)
                    begin
                        if (!best_vld_reg || task_less(rd_task, best_task_reg))
                        begin
                            best_vld_reg  <= 1'b1;
                            best_idx_reg  <= pipe_idx_reg;
                            best_task_reg <= rd_task;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= pipe_idx_reg;
                    end
                end
            end

            // Result handshake; a new result in the same cycle takes precedence.
            if (go)
            begin
                out_valid_reg <= 1'b1;
                disp_reg      <= disp;
                dcpu_reg      <= disp ? fc_idx : '0;
                dtask_reg     <= disp ? chosen : '0;
                drop_reg      <= keep && !slot_ok;
                if (disp)
                begin
                    busy_reg[fc_idx]      <= 1'b1;
                    slot_task_reg[fc_idx] <= chosen;
                end
                if (kind_reg == KIND_STATS)
                begin
                    done_out_reg  <= pd_rd;
                    time_out_reg  <= pt_rd;
                    round_out_reg <= pr_rd;
                    cpu_out_reg   <= ct_rd;
                end
                else
                begin
                    done_out_reg  <= '0;
                    time_out_reg  <= '0;
                    round_out_reg <= '0;
                    cpu_out_reg   <= '0;
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign dispatched        = disp_reg;
    assign dispatch_cpu      = dcpu_reg;
    assign dispatch_task     = dtask_reg.id;
    assign dispatch_priority = dtask_reg.prio;
    assign dropped           = drop_reg;
    assign done_count        = done_out_reg;
    assign busy_time         = time_out_reg;
    assign round_count       = round_out_reg;
    assign cpu_time          = cpu_out_reg;

endmodule

// ===== hdl/mcpd_ready_store.sv =====
`timescale 1ns / 1ps

module mcpd_ready_store
    import mcpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  store_ctrl_t ctrl,
    output task_t       rd_task,
    output logic        rd_valid
);

    task_t mem_reg [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] valid_reg;
    task_t rd_task_reg;
    logic  rd_valid_reg;

    // Task storage and registered read port.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem_reg[ctrl.wr_addr] <= ctrl.wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_task_reg <= mem_reg[ctrl.rd_addr];
        end
    end

    // Valid bits: a clear and a write in the same cycle may hit one slot, and the write wins.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.rd_en)
            begin
                rd_valid_reg <= valid_reg[ctrl.rd_addr];
            end
            if (ctrl.clr_en)
            begin
                valid_reg[ctrl.clr_addr] <= 1'b0;
            end
            if (ctrl.wr_en)
            begin
                valid_reg[ctrl.wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_task  = rd_task_reg;
    assign rd_valid = rd_valid_reg;

endmodule

// ===== sim/tb_multi_cpu_priority_dispatcher_top.sv =====
`timescale 1ns / 1ps

module tb_multi_cpu_priority_dispatcher_top;
    import mcpd_pkg::*;

    // Kind value that the block does not decode.
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 230;
    localparam int DRAIN_CYCLES    = 100;
    localparam int MAX_PRINTS      = 50;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [CPU_W-1:0]  cpu;
        logic              fin;
        logic [STAT_W-1:0] stat;
    } word_t;

    typedef struct packed {
        logic              disp;
        logic [CPU_W-1:0]  cpu;
        logic [ID_W-1:0]   tid;
        logic [PRIO_W-1:0] prio;
        logic              drop;
        logic [CNT_W-1:0]  done;
        logic [CNT_W-1:0]  busy;
        logic [CNT_W-1:0]  rounds;
        logic [CNT_W-1:0]  ctime;
    } result_t;

    typedef struct packed {
        bit      typed;
        word_t   w;
        result_t r;
    } dir_row_t;

    localparam result_t NO_RESULT = '0;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [KIND_W-1:0]  kind = '0;
    logic [ID_W-1:0]    task_id = '0;
    logic [PRIO_W-1:0]  task_priority = '0;
    logic [CPU_W-1:0]   cpu_index = '0;
    logic               finished = 1'b0;
    logic [STAT_W-1:0]  stat_index = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               dispatched;
    logic [CPU_W-1:0]   dispatch_cpu;
    logic [ID_W-1:0]    dispatch_task;
    logic [PRIO_W-1:0]  dispatch_priority;
    logic               dropped;
    logic [CNT_W-1:0]   done_count;
    logic [CNT_W-1:0]   busy_time;
    logic [CNT_W-1:0]   round_count;
    logic [CNT_W-1:0]   cpu_time;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data = '0;

    multi_cpu_priority_dispatcher_top DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .kind              (kind),
        .task_id           (task_id),
        .task_priority     (task_priority),
        .cpu_index         (cpu_index),
        .finished          (finished),
        .stat_index        (stat_index),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .dispatched        (dispatched),
        .dispatch_cpu      (dispatch_cpu),
        .dispatch_task     (dispatch_task),
        .dispatch_priority (dispatch_priority),
        .dropped           (dropped),
        .done_count        (done_count),
        .busy_time         (busy_time),
        .round_count       (round_count),
        .cpu_time          (cpu_time),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data)
    );

    // Shadow copy of the dispatcher state.
    task_t            rs_entry   [QUEUE_DEPTH];
    bit               rs_valid   [QUEUE_DEPTH];
    bit               cpu_busy   [NUM_CPUS];
    task_t            cpu_task   [NUM_CPUS];
    logic [CNT_W-1:0] m_done     [NUM_PRIOS];
    logic [CNT_W-1:0] m_time     [NUM_PRIOS];
    logic [CNT_W-1:0] m_rounds   [NUM_PRIOS];
    logic [CNT_W-1:0] m_cpu_time [NUM_CPUS];
    logic [CFG_W-1:0] m_cpus;

    result_t pending [$];
    result_t rx;
    result_t oldest;
    int      err_count = 0;
    int      send_idle_pct = 0;
    int      stall_pct = 0;

    always #5 clk = ~clk;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input int unsigned b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    // Tasks are ordered by priority, then by id.
    function automatic bit earlier_task(input task_t a, input task_t b);
        if (a.prio != b.prio)
        begin
            return a.prio < b.prio;
        end
        return a.id < b.id;
    endfunction

    // Advances the shadow state by one word and returns the result it must produce.
    function automatic result_t predict_dispatch(input word_t w);
        result_t r;
        task_t   extra;
        task_t   t;
        task_t   chosen;
        bit      has_extra;
        bit      pick;
        bit      stored;
        int      lim;
        int      free_cpu;
        int      best;
        int      dur;
        int      i;
        r = '0;
        extra = '0;
        chosen = '0;
        has_extra = 1'b0;
        pick = 1'b0;
        stored = 1'b0;
        free_cpu = -1;
        best = -1;
        lim = int'(m_cpus);
        if (lim < 1)
        begin
            lim = 1;
        end
        if (lim > NUM_CPUS)
        begin
            lim = NUM_CPUS;
        end

        // A new task or the end of a busy slice.
        if (w.kind == KIND_NEW)
        begin
            extra.id = w.id;
            if (w.prio > TOP_PRIORITY)
            begin
                extra.prio = PRIO_W'(TOP_PRIORITY);
            end
            else
            begin
                extra.prio = w.prio;
            end
            has_extra = 1'b1;
        end
        else if (w.kind == KIND_STATUS && cpu_busy[w.cpu])
        begin
            t = cpu_task[w.cpu];
            dur = SLICE_BASE - int'(t.prio);
            m_time[t.prio] = sat_add(m_time[t.prio], dur);
            m_rounds[t.prio] = sat_add(m_rounds[t.prio], 1);
            m_cpu_time[w.cpu] = sat_add(m_cpu_time[w.cpu], dur);
            cpu_busy[w.cpu] = 1'b0;
            cpu_task[w.cpu] = '0;
            if (w.fin)
            begin
                m_done[t.prio] = sat_add(m_done[t.prio], 1);
            end
            else
            begin
                if (t.prio < TOP_PRIORITY)
                begin
                    t.prio = t.prio + PRIO_W'(1);
                end
                extra = t;
                has_extra = 1'b1;
            end
        end

        // Lowest free CPU and best ready task.
        for (i = 0; i < lim; i++)
        begin
            if (!cpu_busy[i] && free_cpu < 0)
            begin
                free_cpu = i;
            end
        end
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (rs_valid[i] && (best < 0 || earlier_task(rs_entry[i], rs_entry[best])))
            begin
                best = i;
            end
        end

        // Store entries win ties over the task of this word.
        if (free_cpu >= 0)
        begin
            if (has_extra && (best < 0 || earlier_task(extra, rs_entry[best])))
            begin
                chosen = extra;
                has_extra = 1'b0;
                pick = 1'b1;
            end
            else if (best >= 0)
            begin
                chosen = rs_entry[best];
                rs_valid[best] = 1'b0;
                pick = 1'b1;
            end
            if (pick)
            begin
                cpu_busy[free_cpu] = 1'b1;
                cpu_task[free_cpu] = chosen;
                r.disp = 1'b1;
                r.cpu = CPU_W'(free_cpu);
                r.tid = chosen.id;
                r.prio = chosen.prio;
            end
        end

        // A task that found no CPU goes to the first free slot or is lost.
        if (has_extra)
        begin
            for (i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (!rs_valid[i] && !stored)
                begin
                    rs_entry[i] = extra;
                    rs_valid[i] = 1'b1;
                    stored = 1'b1;
                end
            end
            if (!stored)
            begin
                r.drop = 1'b1;
            end
        end

        if (w.kind == KIND_STATS)
        begin
            if (w.stat <= TOP_PRIORITY)
            begin
                r.done = m_done[w.stat];
                r.busy = m_time[w.stat];
                r.rounds = m_rounds[w.stat];
            end
            if (w.stat < NUM_CPUS)
            begin
                r.ctime = m_cpu_time[w.stat];
            end
        end
        return r;
    endfunction

    function automatic word_t mk_word(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] id,
                                      input logic [PRIO_W-1:0] prio, input logic [CPU_W-1:0] c,
                                      input logic fin, input logic [STAT_W-1:0] stat);
        word_t w;
        w.kind = k;
        w.id = id;
        w.prio = prio;
        w.cpu = c;
        w.fin = fin;
        w.stat = stat;
        return w;
    endfunction

    function automatic result_t mk_result(input logic disp, input logic [CPU_W-1:0] c,
                                          input logic [ID_W-1:0] tid,
                                          input logic [PRIO_W-1:0] prio,
                                          input logic [CNT_W-1:0] done,
                                          input logic [CNT_W-1:0] busy,
                                          input logic [CNT_W-1:0] rounds,
                                          input logic [CNT_W-1:0] ctime);
        result_t r;
        r.disp = disp;
        r.cpu = c;
        r.tid = tid;
        r.prio = prio;
        r.drop = 1'b0;
        r.done = done;
        r.busy = busy;
        r.rounds = rounds;
        r.ctime = ctime;
        return r;
    endfunction

    // Mostly well-formed words: slice ends go to busy CPUs, and ids are often small
    // so that equal (priority, id) pairs meet in the store.
    function automatic word_t random_word(input int new_pct);
        word_t w;
        int    r;
        int    busy_cpus [$];
        int    i;
        w = word_t'($urandom);
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            // Noise: every field random, the unused kind included.
        end
        else if (r < 8 + new_pct)
        begin
            w.kind = KIND_NEW;
            if ($urandom_range(0, 1) == 1)
            begin
                w.id = ID_W'($urandom_range(0, 7));
            end
            if ($urandom_range(0, 99) < 85)
            begin
                w.prio = PRIO_W'($urandom_range(0, TOP_PRIORITY));
            end
        end
        else if (r < 20 + new_pct)
        begin
            w.kind = KIND_STATS;
        end
        else
        begin
            w.kind = KIND_STATUS;
            for (i = 0; i < NUM_CPUS; i++)
            begin
                if (cpu_busy[i])
                begin
                    busy_cpus.push_back(i);
                end
            end
            if (busy_cpus.size() > 0)
            begin
                w.cpu = CPU_W'(busy_cpus[$urandom_range(0, busy_cpus.size() - 1)]);
            end
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                   input logic [CNT_W-1:0] want);
        if (err_count < MAX_PRINTS)
        begin
            $display("%0t ns: %s is %0h, expected %0h", $time, what, got, want);
        end
        err_count++;
    endtask

    // Offers one word, waits for its acceptance and records the expected result.
    task automatic send_word(input word_t w, input bit typed, input result_t want);
        result_t p;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= w.kind;
        task_id <= w.id;
        task_priority <= w.prio;
        cpu_index <= w.cpu;
        finished <= w.fin;
        stat_index <= w.stat;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        p = predict_dispatch(w);
        pending.push_back(typed ? want : p);
    endtask

    task automatic write_cpus(input logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        m_cpus = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drops valid and waits until every expected result has come back.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Random receiver back-pressure.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            rx.disp = dispatched;
            rx.cpu = dispatch_cpu;
            rx.tid = dispatch_task;
            rx.prio = dispatch_priority;
            rx.drop = dropped;
            rx.done = done_count;
            rx.busy = busy_time;
            rx.rounds = round_count;
            rx.ctime = cpu_time;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected result, dispatched", CNT_W'(rx.disp), CNT_W'(0));
            end
            else
            begin
                oldest = pending.pop_front();
                if (rx.disp !== oldest.disp)
                    report_mismatch("dispatched", CNT_W'(rx.disp), CNT_W'(oldest.disp));
                if (rx.cpu !== oldest.cpu)
                    report_mismatch("dispatch_cpu", CNT_W'(rx.cpu), CNT_W'(oldest.cpu));
                if (rx.tid !== oldest.tid)
                    report_mismatch("dispatch_task", CNT_W'(rx.tid), CNT_W'(oldest.tid));
                if (rx.prio !== oldest.prio)
                    report_mismatch("dispatch_priority", CNT_W'(rx.prio), CNT_W'(oldest.prio));
                if (rx.drop !== oldest.drop)
                    report_mismatch("dropped", CNT_W'(rx.drop), CNT_W'(oldest.drop));
                if (rx.done !== oldest.done)
                    report_mismatch("done_count", rx.done, oldest.done);
                if (rx.busy !== oldest.busy)
                    report_mismatch("busy_time", rx.busy, oldest.busy);
                if (rx.rounds !== oldest.rounds)
                    report_mismatch("round_count", rx.rounds, oldest.rounds);
                if (rx.ctime !== oldest.ctime)
                    report_mismatch("cpu_time", rx.ctime, oldest.ctime);
            end
        end
    end

    // Main sequence: reset, directed words, then random phases.
    initial
    begin
        dir_row_t          dir_rows [$];
        int                p;
        int                n;
        int                new_pct;
        logic [CFG_W-1:0]  cfg_val;

        // Shadow state after reset.
        for (n = 0; n < QUEUE_DEPTH; n++)
        begin
            rs_entry[n] = '0;
            rs_valid[n] = 1'b0;
        end
        for (n = 0; n < NUM_CPUS; n++)
        begin
            cpu_busy[n] = 1'b0;
            cpu_task[n] = '0;
            m_cpu_time[n] = '0;
        end
        for (n = 0; n < NUM_PRIOS; n++)
        begin
            m_done[n] = '0;
            m_time[n] = '0;
            m_rounds[n] = '0;
        end
        m_cpus = 4'd8;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset setting of eight CPUs.
        dir_rows.push_back('{1'b1, mk_word(KIND_STATS, 0, 0, 0, 0, 0), NO_RESULT});
        // Priority above the top is clamped; first free CPU is 0.
        dir_rows.push_back('{1'b1, mk_word(KIND_NEW, 16'hFFFF, 4'hF, 0, 0, 0),
                             mk_result(1, 0, 16'hFFFF, 9, 0, 0, 0, 0)});
        dir_rows.push_back('{1'b1, mk_word(KIND_NEW, 0, 0, 0, 0, 0),
                             mk_result(1, 1, 0, 0, 0, 0, 0, 0)});
        // A status word for an idle CPU changes nothing.
        dir_rows.push_back('{1'b1, mk_word(KIND_STATUS, 0, 0, 7, 0, 0), NO_RESULT});
        dir_rows.push_back('{1'b1, mk_word(KIND_NONE, 16'hFFFF, 4'hF, 7, 1, 4'hF), NO_RESULT});
        // The priority 0 task on CPU 1 finishes after a slice of 20.
        dir_rows.push_back('{1'b1, mk_word(KIND_STATUS, 0, 0, 1, 1, 0), NO_RESULT});
        dir_rows.push_back('{1'b1, mk_word(KIND_STATS, 0, 0, 0, 0, 0),
                             mk_result(0, 0, 0, 0, 1, 20, 1, 0)});
        dir_rows.push_back('{1'b1, mk_word(KIND_STATS, 0, 0, 0, 0, 1),
                             mk_result(0, 0, 0, 0, 0, 0, 0, 20)});
        // Preempted at the top priority, it stays there and goes straight back to CPU 0.
        dir_rows.push_back('{1'b1, mk_word(KIND_STATUS, 0, 0, 0, 0, 0),
                             mk_result(1, 0, 16'hFFFF, 9, 0, 0, 0, 0)});
        dir_rows.push_back('{1'b1, mk_word(KIND_STATS, 0, 0, 0, 0, 9),
                             mk_result(0, 0, 0, 0, 0, 11, 1, 0)});
        // Stats index 15 lies beyond the priorities and the CPUs and reads zero; index 8 reads no CPU time.
        dir_rows.push_back('{1'b1, mk_word(KIND_STATS, 0, 0, 0, 0, 4'hF), NO_RESULT});
        dir_rows.push_back('{1'b1, mk_word(KIND_STATS, 0, 0, 0, 0, 8), NO_RESULT});
        // Fill the remaining CPUs, then queue equal and near-equal tasks.
        dir_rows.push_back('{1'b0, mk_word(KIND_NEW, 16'h1234, 2, 0, 0, 0), NO_RESULT});
        dir_rows.push_back('{1'b0, mk_word(KIND_NEW, 16'h0001, 9, 0, 0, 0), NO_RESULT});
        dir_rows.push_back('{1'b0, mk_word(KIND_NEW, 16'h8000, 0, 0, 0, 0), NO_RESULT});
        dir_rows.push_back('{1'b0, mk_word(KIND_NEW, 16'h00FF, 5, 0, 0, 0), NO_RESULT});
        dir_rows.push_back('{1'b0, mk_word(KIND_NEW, 16'h0007, 3, 0, 0, 0), NO_RESULT});
        dir_rows.push_back('{1'b0, mk_word(KIND_NEW, 16'h7FFF, 1, 0, 0, 0), NO_RESULT});
        dir_rows.push_back('{1'b0, mk_word(KIND_NEW, 16'h0100, 4, 0, 0, 0), NO_RESULT});
        dir_rows.push_back('{1'b0, mk_word(KIND_NEW, 5, 3, 0, 0, 0), NO_RESULT});
        dir_rows.push_back('{1'b0, mk_word(KIND_NEW, 5, 3, 0, 0, 0), NO_RESULT});
        dir_rows.push_back('{1'b0, mk_word(KIND_NEW, 4, 3, 0, 0, 0), NO_RESULT});
        dir_rows.push_back('{1'b0, mk_word(KIND_STATUS, 0, 0, 5, 0, 0), NO_RESULT});
        dir_rows.push_back('{1'b0, mk_word(KIND_STATUS, 0, 0, 3, 0, 0), NO_RESULT});
        dir_rows.push_back('{1'b0, mk_word(KIND_STATS, 0, 0, 0, 0, 3), NO_RESULT});

        foreach (dir_rows[n])
        begin
            send_word(dir_rows[n].w, dir_rows[n].typed, dir_rows[n].r);
        end

        // Random phases: each writes a CPU count, including 0 and 15, then runs
        // either a filling or a draining mix under one idling pattern.
        for (p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            repeat (4) @(negedge clk);
            case (p)
                0: begin cfg_val = 4'd1;  new_pct = 55; end
                1: begin cfg_val = 4'd8;  new_pct = 15; end
                2: begin cfg_val = 4'd0;  new_pct = 60; end
                3: begin cfg_val = 4'd15; new_pct = 15; end
                4: begin cfg_val = 4'd3;  new_pct = 50; end
                5: begin cfg_val = 4'd5;  new_pct = 10; end
                6: begin cfg_val = 4'd2;  new_pct = 55; end
                default: begin cfg_val = 4'd8; new_pct = 10; end
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 53; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 53; end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase
            write_cpus(cfg_val);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                send_word(random_word(new_pct), 1'b0, NO_RESULT);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (err_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #(20_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
